FILE: rtl/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define EVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Expression must hold at every enabled clock edge
`define EVR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

FILE: rtl/evr_pkg.sv
`timescale 1ns / 1ps
// Package for the Euler vector rotation block: widths, fixed-point constants,
// rounding helper and the matrix type. No dependencies.
package evr_pkg;

	localparam int DATA_W         = 32;
	localparam int QI             = 29;
	localparam int ANGLE_FRAC_DEF = 24;
	// Reduced angle width: holds any in-range Q29 angle
	localparam int RED_W          = 37;
	localparam int KMAX           = 6;
	localparam int MAT_W          = 34;

	localparam longint Q_PI      = 64'sd1686629713;
	localparam longint Q_HALF_PI = 64'sd843314857;
	localparam longint Q_TWO_PI  = 64'sd3373259426;
	localparam longint Q_LIMIT   = 64'sd33 * (64'sd1 <<< QI);

	localparam logic signed [DATA_W-1:0] C3 = -32'sd89478434;
	localparam logic signed [DATA_W-1:0] C5 = 32'sd4473755;
	localparam logic signed [DATA_W-1:0] C7 = -32'sd106336;
	localparam logic signed [DATA_W-1:0] C9 = 32'sd1396;

	typedef struct packed {
		logic signed [MAT_W-1:0] e00;
		logic signed [MAT_W-1:0] e01;
		logic signed [MAT_W-1:0] e02;
		logic signed [MAT_W-1:0] e10;
		logic signed [MAT_W-1:0] e11;
		logic signed [MAT_W-1:0] e12;
		logic signed [MAT_W-1:0] e20;
		logic signed [MAT_W-1:0] e21;
		logic signed [MAT_W-1:0] e22;
	} evr_matrix_t;

	// Round a Q29 x Q29 product back to Q29, ties up
	function automatic logic signed [DATA_W-1:0] rnd_q(input logic signed [2*DATA_W-1:0] p);
		logic signed [2*DATA_W-1:0] w;
		w = p + (64'sd1 <<< (QI - 1));
		return DATA_W'(w >>> QI);
	endfunction

	// Odd multiple of pi used as a reduction threshold
	function automatic logic signed [RED_W-1:0] odd_pi(input int m);
		return RED_W'(longint'(2 * m - 1) * Q_PI);
	endfunction

endpackage

FILE: rtl/evr_in_if.sv
`timescale 1ns / 1ps
// Input channel: vector and three angles with valid/ready.
// Depends on evr_pkg.
interface evr_in_if import evr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] vec_x;
	logic signed [DATA_W-1:0] vec_y;
	logic signed [DATA_W-1:0] vec_z;
	logic signed [DATA_W-1:0] roll_angle;
	logic signed [DATA_W-1:0] pitch_angle;
	logic signed [DATA_W-1:0] yaw_angle;

	modport source (output valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
		input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
		output ready);
endinterface

FILE: rtl/evr_out_if.sv
`timescale 1ns / 1ps
// Output channel: rotated vector with valid/ready.
// Depends on evr_pkg.
interface evr_out_if import evr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] rot_x;
	logic signed [DATA_W-1:0] rot_y;
	logic signed [DATA_W-1:0] rot_z;

	modport source (output valid, rot_x, rot_y, rot_z, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

FILE: rtl/evr_sine.sv
`timescale 1ns / 1ps
// Nine-stage polynomial sine (or cosine) of one Q.ANGLE_FRAC_BITS angle, result in Q29.
// Depends on evr_pkg.
module evr_sine import evr_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic                     phase,
	input  logic signed [DATA_W-1:0] angle,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] sine
);

	localparam int SH = QI - ANGLE_FRAC_BITS;
	localparam int WQ = DATA_W + SH + 1;
	localparam logic signed [WQ-1:0]    LIM_Q  = WQ'(Q_LIMIT);
	localparam logic signed [WQ-1:0]    HPI_Q  = WQ'(Q_HALF_PI);
	localparam logic signed [RED_W-1:0] PI_R   = RED_W'(Q_PI);
	localparam logic signed [RED_W-1:0] HPI_R  = RED_W'(Q_HALF_PI);
	localparam logic signed [RED_W-1:0] TPI_R  = RED_W'(Q_TWO_PI);

	logic signed [WQ-1:0]       x_full;
	logic                       oor;
	logic signed [3:0]          k_c;
	logic signed [RED_W-1:0]    k_off;
	logic signed [RED_W-1:0]    x_refl;
	logic signed [2*DATA_W-1:0] p_xx, p_xx2, p_t1, p_t2, p_t3, p_out;

	logic [8:0]                 v_q;
	logic [7:0]                 z_q;
	logic signed [RED_W-1:0]    x_s1, x_s2, x_s3;
	logic signed [3:0]          k_s2;
	logic signed [DATA_W-1:0]   x_s4, x_s5, x_s6, x_s7, x_s8;
	logic signed [DATA_W-1:0]   x2_s5, x2_s6, x2_s7;
	logic signed [DATA_W-1:0]   xx2_s6, xx2_s7, xx2_s8;
	logic signed [DATA_W-1:0]   t_s6, t_s7, t_s8;
	logic signed [DATA_W-1:0]   sine_s9;

	// Convert to Q29, add the cosine phase, test the range
	always_comb begin
		x_full = (WQ'(angle) <<< SH) + (phase ? HPI_Q : WQ'(0));
		oor    = (x_full >= LIM_Q) || (x_full <= -LIM_Q);
	end

	// Count the 2pi multiples to remove
	always_comb begin
		k_c = 4'sd0;
		for (int m = 1; m <= KMAX; m++) begin
			if (x_s1 > odd_pi(m))
				k_c = k_c + 4'sd1;
			else if (x_s1 < -odd_pi(m))
				k_c = k_c - 4'sd1;
		end
	end

	// Remove the multiples, then reflect into [-pi/2, pi/2]
	always_comb begin
		k_off = k_s2 * TPI_R;
		if (x_s3 > HPI_R)
			x_refl = PI_R - x_s3;
		else if (x_s3 < -HPI_R)
			x_refl = -PI_R - x_s3;
		else
			x_refl = x_s3;
	end

	// Horner products
	always_comb begin
		p_xx  = x_s4 * x_s4;
		p_xx2 = x_s5 * x2_s5;
		p_t1  = x2_s5 * C9;
		p_t2  = x2_s6 * t_s6;
		p_t3  = x2_s7 * t_s7;
		p_out = xx2_s8 * t_s8;
	end

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[7:0], in_valid};
		end
	end

	// Advance the data stages
	always_ff @(posedge clk) begin
		if (en) begin
			z_q     <= {z_q[6:0], oor};
			x_s1    <= x_full[RED_W-1:0];
			x_s2    <= x_s1;
			k_s2    <= k_c;
			x_s3    <= x_s2 - k_off;
			x_s4    <= DATA_W'(x_refl);
			x_s5    <= x_s4;
			x2_s5   <= rnd_q(p_xx);
			x_s6    <= x_s5;
			x2_s6   <= x2_s5;
			xx2_s6  <= rnd_q(p_xx2);
			t_s6    <= C7 + rnd_q(p_t1);
			x_s7    <= x_s6;
			x2_s7   <= x2_s6;
			xx2_s7  <= xx2_s6;
			t_s7    <= C5 + rnd_q(p_t2);
			x_s8    <= x_s7;
			xx2_s8  <= xx2_s7;
			t_s8    <= C3 + rnd_q(p_t3);
			sine_s9 <= z_q[7] ? '0 : x_s8 + rnd_q(p_out);
		end
	end

	assign out_valid = v_q[8];
	assign sine      = sine_s9;

endmodule

FILE: rtl/evr_matrix.sv
`timescale 1ns / 1ps
// Two-stage build of the Euler matrix from the six sines and cosines.
// Depends on evr_pkg.
module evr_matrix import evr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] sx,
	input  logic signed [DATA_W-1:0] cx,
	input  logic signed [DATA_W-1:0] sy,
	input  logic signed [DATA_W-1:0] cy,
	input  logic signed [DATA_W-1:0] sz,
	input  logic signed [DATA_W-1:0] cz,
	output logic                     out_valid,
	output evr_matrix_t              mat
);

	logic signed [2*DATA_W-1:0] p_czcx, p_szcx, p_czsx, p_szsx;
	logic signed [2*DATA_W-1:0] p_czcy, p_cysz, p_sxcy, p_cycx;
	logic signed [2*DATA_W-1:0] p_a, p_b, p_c, p_d;
	logic                       v_s1, v_s2;
	logic signed [DATA_W-1:0]   czcx_s1, szcx_s1, czsx_s1, szsx_s1, sy_s1;
	logic signed [DATA_W-1:0]   czcy_s1, cysz_s1, sxcy_s1, cycx_s1;
	evr_matrix_t                mat_s2;

	// Pair products
	always_comb begin
		p_czcx = cz * cx;
		p_szcx = sz * cx;
		p_czsx = sx * cz;
		p_szsx = sx * sz;
		p_czcy = cz * cy;
		p_cysz = cy * sz;
		p_sxcy = sx * cy;
		p_cycx = cy * cx;
		p_a    = czsx_s1 * sy_s1;
		p_b    = szsx_s1 * sy_s1;
		p_c    = czcx_s1 * sy_s1;
		p_d    = szcx_s1 * sy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Hold the pair products, then form the nine entries
	always_ff @(posedge clk) begin
		if (en) begin
			czcx_s1    <= rnd_q(p_czcx);
			szcx_s1    <= rnd_q(p_szcx);
			czsx_s1    <= rnd_q(p_czsx);
			szsx_s1    <= rnd_q(p_szsx);
			czcy_s1    <= rnd_q(p_czcy);
			cysz_s1    <= rnd_q(p_cysz);
			sxcy_s1    <= rnd_q(p_sxcy);
			cycx_s1    <= rnd_q(p_cycx);
			sy_s1      <= sy;
			mat_s2.e00 <= MAT_W'(czcy_s1);
			mat_s2.e01 <= -MAT_W'(cysz_s1);
			mat_s2.e02 <= MAT_W'(sy_s1);
			mat_s2.e10 <= MAT_W'(szcx_s1) + MAT_W'(rnd_q(p_a));
			mat_s2.e11 <= MAT_W'(czcx_s1) - MAT_W'(rnd_q(p_b));
			mat_s2.e12 <= -MAT_W'(sxcy_s1);
			mat_s2.e20 <= MAT_W'(szsx_s1) - MAT_W'(rnd_q(p_c));
			mat_s2.e21 <= MAT_W'(czsx_s1) + MAT_W'(rnd_q(p_d));
			mat_s2.e22 <= MAT_W'(cycx_s1);
		end
	end

	assign out_valid = v_s2;
	assign mat       = mat_s2;

endmodule

FILE: rtl/evr_apply.sv
`timescale 1ns / 1ps
// Two-stage transpose-matrix times vector with rounding and saturation.
// Depends on evr_pkg.
module evr_apply import evr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] vx,
	input  logic signed [DATA_W-1:0] vy,
	input  logic signed [DATA_W-1:0] vz,
	input  evr_matrix_t              mat,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] rx,
	output logic signed [DATA_W-1:0] ry,
	output logic signed [DATA_W-1:0] rz
);

	localparam int PW = DATA_W + MAT_W;
	localparam int SW = PW + 2;
	localparam int RW = SW - QI;
	localparam logic signed [RW-1:0] MAXV = RW'(64'sd2147483647);
	localparam logic signed [RW-1:0] MINV = RW'(-64'sd2147483648);

	logic signed [PW-1:0]     p0x_s1, p1x_s1, p2x_s1;
	logic signed [PW-1:0]     p0y_s1, p1y_s1, p2y_s1;
	logic signed [PW-1:0]     p0z_s1, p1z_s1, p2z_s1;
	logic signed [SW-1:0]     sum_x, sum_y, sum_z;
	logic signed [RW-1:0]     r_x, r_y, r_z;
	logic signed [DATA_W-1:0] rx_s2, ry_s2, rz_s2;
	logic                     v_s1, v_s2;

	// Saturate a rounded sum to 32 bits
	function automatic logic signed [DATA_W-1:0] sat(input logic signed [RW-1:0] r);
		if (r > MAXV)
			return DATA_W'(MAXV);
		else if (r < MINV)
			return DATA_W'(MINV);
		else
			return DATA_W'(r);
	endfunction

	// Sum exactly, then round
	always_comb begin
		sum_x = SW'(p0x_s1) + SW'(p1x_s1) + SW'(p2x_s1);
		sum_y = SW'(p0y_s1) + SW'(p1y_s1) + SW'(p2y_s1);
		sum_z = SW'(p0z_s1) + SW'(p1z_s1) + SW'(p2z_s1);
		r_x   = RW'((sum_x + (SW'(1) <<< (QI - 1))) >>> QI);
		r_y   = RW'((sum_y + (SW'(1) <<< (QI - 1))) >>> QI);
		r_z   = RW'((sum_z + (SW'(1) <<< (QI - 1))) >>> QI);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Hold the nine products, then the saturated results
	always_ff @(posedge clk) begin
		if (en) begin
			p0x_s1 <= vx * mat.e00;
			p1x_s1 <= vy * mat.e10;
			p2x_s1 <= vz * mat.e20;
			p0y_s1 <= vx * mat.e01;
			p1y_s1 <= vy * mat.e11;
			p2y_s1 <= vz * mat.e21;
			p0z_s1 <= vx * mat.e02;
			p1z_s1 <= vy * mat.e12;
			p2z_s1 <= vz * mat.e22;
			rx_s2  <= sat(r_x);
			ry_s2  <= sat(r_y);
			rz_s2  <= sat(r_z);
		end
	end

	assign out_valid = v_s2;
	assign rx        = rx_s2;
	assign ry        = ry_s2;
	assign rz        = rz_s2;

endmodule

FILE: rtl/euler_vector_rotation_top.sv
`timescale 1ns / 1ps
// Top level of the Euler vector rotation pipeline.
// Depends on evr_pkg, evr_in_if, evr_out_if, evr_sine, evr_matrix, evr_apply.
//
//  Channel  | Dir | Payload
//  ---------+-----+---------------------------------------------------------
//  sample   | in  | vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle
//  result   | out | rot_x, rot_y, rot_z
//
// One item per cycle while result is not stalled; each item passes through the sine
// units, then the matrix build, then the multiply-accumulate.
// Reset clears only the valid bits; no clearing pass.
// A stall on result freezes the whole pipeline in place; sample.ready drops
// only while a finished item is held.
`include "assert_macros.svh"
module euler_vector_rotation_top import evr_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input logic       clk,
	input logic       arst_n,
	evr_in_if.sink    sample,
	evr_out_if.source result
);

	localparam int VDEPTH = 9;

	logic                     en;
	logic                     sin_valid;
	logic [5:0]               unit_valid;
	logic signed [DATA_W-1:0] sx, cx, sy, cy, sz, cz;
	logic signed [DATA_W-1:0] vx_q [VDEPTH];
	logic signed [DATA_W-1:0] vy_q [VDEPTH];
	logic signed [DATA_W-1:0] vz_q [VDEPTH];
	logic signed [DATA_W-1:0] vx_m, vy_m, vz_m;
	logic                     mat_valid;
	evr_matrix_t              mat;

	// Advance everything unless a finished item is stalled
	assign en           = !result.valid || result.ready;
	assign sample.ready = en;
	assign sin_valid    = unit_valid[0];

	evr_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sx (.clk, .arst_n, .en,
		.in_valid(sample.valid), .phase(1'b0), .angle(sample.roll_angle),
		.out_valid(unit_valid[0]), .sine(sx));
	evr_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cx (.clk, .arst_n, .en,
		.in_valid(sample.valid), .phase(1'b1), .angle(sample.roll_angle),
		.out_valid(unit_valid[1]), .sine(cx));
	evr_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sy (.clk, .arst_n, .en,
		.in_valid(sample.valid), .phase(1'b0), .angle(sample.pitch_angle),
		.out_valid(unit_valid[2]), .sine(sy));
	evr_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cy (.clk, .arst_n, .en,
		.in_valid(sample.valid), .phase(1'b1), .angle(sample.pitch_angle),
		.out_valid(unit_valid[3]), .sine(cy));
	evr_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sz (.clk, .arst_n, .en,
		.in_valid(sample.valid), .phase(1'b0), .angle(sample.yaw_angle),
		.out_valid(unit_valid[4]), .sine(sz));
	evr_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cz (.clk, .arst_n, .en,
		.in_valid(sample.valid), .phase(1'b1), .angle(sample.yaw_angle),
		.out_valid(unit_valid[5]), .sine(cz));

	// Delay the vector alongside the sine units
	always_ff @(posedge clk) begin
		if (en) begin
			vx_q[0] <= sample.vec_x;
			vy_q[0] <= sample.vec_y;
			vz_q[0] <= sample.vec_z;
			for (int i = 1; i < VDEPTH; i++) begin
				vx_q[i] <= vx_q[i-1];
				vy_q[i] <= vy_q[i-1];
				vz_q[i] <= vz_q[i-1];
			end
		end
	end

	// Two more stages to line up with the matrix output
	logic signed [DATA_W-1:0] vx_s1, vy_s1, vz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1 <= vx_q[VDEPTH-1];
			vy_s1 <= vy_q[VDEPTH-1];
			vz_s1 <= vz_q[VDEPTH-1];
			vx_m  <= vx_s1;
			vy_m  <= vy_s1;
			vz_m  <= vz_s1;
		end
	end

	evr_matrix u_matrix (.clk, .arst_n, .en, .in_valid(sin_valid),
		.sx, .cx, .sy, .cy, .sz, .cz, .out_valid(mat_valid), .mat);

	evr_apply u_apply (.clk, .arst_n, .en, .in_valid(mat_valid),
		.vx(vx_m), .vy(vy_m), .vz(vz_m), .mat,
		.out_valid(result.valid), .rx(result.rot_x), .ry(result.rot_y), .rz(result.rot_z));

	// Checks
	`EVR_ASSERT_IMP(a_stall_blocks, clk, arst_n, result.valid && !result.ready, !sample.ready, "item accepted while output stalled")
	`EVR_ASSERT_IMP(a_ready_cause, clk, arst_n, !sample.ready, result.valid, "input blocked with no result held")
	`EVR_ASSERT_ALWAYS(a_units_aligned, clk, arst_n, unit_valid == 6'b000000 || unit_valid == 6'b111111, "sine units out of step")
	`EVR_ASSERT_IMP(a_sine_bound, clk, arst_n, sin_valid, sx <= 32'sd538968064 && sx >= -32'sd538968064 && cx <= 32'sd538968064 && cx >= -32'sd538968064, "roll sine out of range")

endmodule

FILE: tb/evr_checker.sv
`timescale 1ns / 1ps
// Rotation checker: watches the sample and result channels, predicts each rotated
// vector and compares it with what the block returns. Depends on evr_pkg, evr_in_if, evr_out_if.
module evr_checker import evr_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	evr_in_if          sample,
	evr_out_if         result,
	output int         fail_count,
	output int         pending,
	output int         checked,
	output int         saturated
);

	typedef struct {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} rot_vec_t;

	rot_vec_t rotated_q[$];

	// Round a Q29 product to nearest, tie going up
	function automatic longint round_q29(input longint p);
		return (p + (64'sd1 <<< 28)) >>> 29;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return round_q29(a * b);
	endfunction

	// Polynomial sine of a Q29 angle
	function automatic longint poly_sin(input longint a);
		longint x2, t;
		if (a >= 64'sd17716740096 || a <= -64'sd17716740096)
			return 0;
		if (a > 64'sd1686629713)
			a -= ((a - 64'sd1686629713 + 64'sd3373259425) / 64'sd3373259426) * 64'sd3373259426;
		else if (a < -64'sd1686629713)
			a += ((-64'sd1686629713 - a + 64'sd3373259425) / 64'sd3373259426)
				* 64'sd3373259426;
		if (a > 64'sd843314857)
			a = 64'sd1686629713 - a;
		else if (a < -64'sd843314857)
			a = -64'sd1686629713 - a;
		x2 = qmul(a, a);
		t = 64'sd1396;
		t = -64'sd106336 + qmul(x2, t);
		t = 64'sd4473755 + qmul(x2, t);
		t = -64'sd89478434 + qmul(x2, t);
		return a + qmul(qmul(a, x2), t);
	endfunction

	// Round the accumulated sum and clamp to 32 bits
	function automatic logic signed [DATA_W-1:0] clamp_out(input longint acc, inout int sat);
		longint r;
		r = round_q29(acc);
		if (r > 64'sd2147483647) begin
			sat++;
			return 32'sh7fffffff;
		end
		if (r < -64'sd2147483648) begin
			sat++;
			return 32'sh80000000;
		end
		return r[DATA_W-1:0];
	endfunction

	function automatic rot_vec_t rotate_vec(input logic signed [DATA_W-1:0] vx, vy, vz,
		input logic signed [DATA_W-1:0] roll, pitch, yaw, inout int sat);
		longint ar, ap, ay, cx, sx, cy, sy, cz, sz;
		longint czcx, szcx, czsx, szsx;
		longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
		longint x, y, z;
		rot_vec_t r;
		ar = longint'(roll) <<< (QI - ANGLE_FRAC_BITS);
		ap = longint'(pitch) <<< (QI - ANGLE_FRAC_BITS);
		ay = longint'(yaw) <<< (QI - ANGLE_FRAC_BITS);
		cx = poly_sin(ar + Q_HALF_PI);
		sx = poly_sin(ar);
		cy = poly_sin(ap + Q_HALF_PI);
		sy = poly_sin(ap);
		cz = poly_sin(ay + Q_HALF_PI);
		sz = poly_sin(ay);
		czcx = qmul(cz, cx);
		szcx = qmul(sz, cx);
		czsx = qmul(sx, cz);
		szsx = qmul(sx, sz);
		m00 = qmul(cz, cy);
		m01 = -qmul(cy, sz);
		m02 = sy;
		m10 = szcx + qmul(czsx, sy);
		m11 = czcx - qmul(szsx, sy);
		m12 = -qmul(sx, cy);
		m20 = szsx - qmul(czcx, sy);
		m21 = czsx + qmul(szcx, sy);
		m22 = qmul(cy, cx);
		x = vx;
		y = vy;
		z = vz;
		r.x = clamp_out(x * m00 + y * m10 + z * m20, sat);
		r.y = clamp_out(x * m01 + y * m11 + z * m21, sat);
		r.z = clamp_out(x * m02 + y * m12 + z * m22, sat);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] got,
		input logic signed [DATA_W-1:0] want);
		$display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
		saturated = 0;
	end

	// Predict on each accepted sample, compare on each accepted result
	always @(posedge clk) begin
		rot_vec_t w;
		if (arst_n) begin
			if (sample.valid && sample.ready)
				rotated_q.push_back(rotate_vec(sample.vec_x, sample.vec_y, sample.vec_z,
					sample.roll_angle, sample.pitch_angle, sample.yaw_angle, saturated));
			if (result.valid && result.ready) begin
				if (rotated_q.size() == 0) begin
					$display("%0t ns: result with no sample outstanding", $time);
					fail_count++;
				end else begin
					w = rotated_q.pop_front();
					checked++;
					if (result.rot_x !== w.x) report_mismatch("rot_x", result.rot_x, w.x);
					if (result.rot_y !== w.y) report_mismatch("rot_y", result.rot_y, w.y);
					if (result.rot_z !== w.z) report_mismatch("rot_z", result.rot_z, w.z);
				end
			end
		end
		pending = rotated_q.size();
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the rotation testbench: clock, reset, sample stimulus with bursts and gaps,
// result back-pressure and verdict. Depends on evr_pkg, the channel interfaces, evr_checker.
module testbench import evr_pkg::*;;

	localparam int RANDOM_ITEMS = 830;
	localparam int IDLE_LIMIT   = 4000;
	// Q8.24 encodings of angles used by the directed items
	localparam logic signed [31:0] A_PI      = 32'sd52707179;
	localparam logic signed [31:0] A_HALF_PI = 32'sd26353589;
	localparam logic signed [31:0] A_QUARTER = 32'sd13176795;
	localparam logic signed [31:0] A_LIMIT   = 32'sd553648128;

	logic clk;
	logic arst_n;
	int   fail_count, pending, checked, saturated;
	int   idle_cycles;
	int   burst_left;
	int   sent;

	evr_in_if  sample ();
	evr_out_if result ();

	euler_vector_rotation_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result)
	);

	evr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.saturated  (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall results on a pattern picked at random from four modes, picked anew when a counter runs out
	always @(negedge clk) begin
		int mode_cnt;
		int mode;
		if (!arst_n) begin
			result.ready <= 1'b0;
			mode_cnt = 0;
			mode = 0;
		end else begin
			if (mode_cnt == 0) begin
				mode = $urandom_range(0, 3);
				mode_cnt = 64;
			end
			mode_cnt--;
			case (mode)
				0: result.ready <= 1'b1;
				1: result.ready <= ($urandom_range(0, 1) == 1);
				2: result.ready <= ($urandom_range(0, 3) != 0);
				default: result.ready <= ((mode_cnt % 16) < 4);
			endcase
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (sample.valid && sample.ready) || (result.valid && result.ready))
			idle_cycles = 0;
		else if (++idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one item; hold it until accepted, then at the end of a burst sometimes insert a gap
	task automatic push_sample(input logic signed [31:0] vx, vy, vz, roll, pitch, yaw);
		sample.valid       <= 1'b1;
		sample.vec_x       <= vx;
		sample.vec_y       <= vy;
		sample.vec_z       <= vz;
		sample.roll_angle  <= roll;
		sample.pitch_angle <= pitch;
		sample.yaw_angle   <= yaw;
		do @(posedge clk); while (!sample.ready);
		@(negedge clk);
		sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
				: $urandom_range(0, 8);
			if ($urandom_range(0, 2) != 0) begin
				sample.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	endtask

	function automatic logic signed [31:0] pick_angle();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom();
			2:       return A_LIMIT + $urandom_range(0, 600) - 300;
			3:       return -A_LIMIT + $urandom_range(0, 600) - 300;
			default: return $signed($urandom_range(0, 32'd268435456)) - 32'sd134217728;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_vec();
		case ($urandom_range(0, 5))
			0, 1:    return $urandom();
			2:       return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	initial begin
		sample.valid       = 1'b0;
		sample.vec_x       = '0;
		sample.vec_y       = '0;
		sample.vec_z       = '0;
		sample.roll_angle  = '0;
		sample.pitch_angle = '0;
		sample.yaw_angle   = '0;
		arst_n = 1'b0;
		burst_left = 0;
		sent = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero angles, exact quadrant angles, vector extremes
		push_sample(0, 0, 0, 0, 0, 0);
		push_sample(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 0, 0, 0);
		push_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
		push_sample(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
		push_sample(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, A_QUARTER);
		push_sample(32'sh80000000, 32'sh80000000, 32'sh80000000,
			A_QUARTER, A_QUARTER, A_QUARTER);
		push_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, A_PI, -A_PI, A_PI);
		push_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
			A_HALF_PI, -A_HALF_PI, A_HALF_PI);
		push_sample(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000,
			A_PI + 1, -A_PI - 1, 3 * A_PI);
		// Out-of-range angles for sine and for the shifted cosine
		push_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			A_LIMIT, -A_LIMIT, A_LIMIT - 1);
		push_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			-A_LIMIT + 1, A_LIMIT - A_HALF_PI, -A_LIMIT - A_HALF_PI);
		push_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		push_sample(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		push_sample(32'shffffffff, 1, 32'shffffffff, -1, 1, -1);
		push_sample(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
			32'sh0555_5555, 32'shfaaa_aaaa, 32'sh0155_5555);

		// Random samples
		repeat (RANDOM_ITEMS)
			push_sample(pick_vec(), pick_vec(), pick_vec(),
				pick_angle(), pick_angle(), pick_angle());
		sample.valid <= 1'b0;

		// Drain, then allow for the pipeline latency
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("Sent %0d samples (directed quadrant, extreme and out-of-range angles, then random)",
			sent);
		$display("Checked %0d rotated vectors, %0d saturated components", checked, saturated);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/evr_pkg.sv
rtl/evr_in_if.sv
rtl/evr_out_if.sv
rtl/evr_sine.sv
rtl/evr_matrix.sv
rtl/evr_apply.sv
rtl/euler_vector_rotation_top.sv
tb/evr_checker.sv
tb/testbench.sv
